// ----- hw/rtl/gcfrm_pkg.sv -----
// shared types and constants for the g-code line framer
`default_nettype none

package gcfrm_pkg;

  // line counter width; the decimal counter has enough digits for its largest value
  localparam int LINE_COUNT_BITS = 32;
  localparam int BCD_DIGITS      = (LINE_COUNT_BITS * 30103 + 99999) / 100000;
  localparam int DIG_IDX_W       = $clog2(BCD_DIGITS);

  // checksum is one byte, at most three decimal digits
  localparam int CS_DIGITS = 3;
  localparam int CS_IDX_W  = 2;

  // queue depths
  localparam int FQ_DEPTH = 4;
  localparam int FQ_PTR_W = $clog2(FQ_DEPTH);
  localparam int FQ_CNT_W = $clog2(FQ_DEPTH + 1);
  localparam int OQ_DEPTH = 2;
  localparam int OQ_PTR_W = $clog2(OQ_DEPTH);
  localparam int OQ_CNT_W = $clog2(OQ_DEPTH + 1);

  // framing characters
  localparam logic [7:0] CH_N     = 8'h4E;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_STAR  = 8'h2A;
  localparam logic [7:0] CH_NL    = 8'h0A;
  localparam logic [7:0] CH_ZERO  = 8'h30;

  typedef struct packed {
    logic [7:0] cmd_byte;
    logic       line_last;
  } in_item_t;

  typedef struct packed {
    logic [7:0] out_byte;
    logic       run_last;
    logic       line_end;
  } out_item_t;

  // classified command byte as held in the front queue
  typedef struct packed {
    logic [7:0] cmd_byte;
    logic       line_first;
    logic       line_last;
  } fq_item_t;

  typedef struct packed {
    logic     valid;
    fq_item_t item;
  } fq_head_t;

  typedef struct packed {
    logic      valid;
    out_item_t item;
  } oq_push_t;

  typedef enum logic [2:0] {
    ST_FETCH,
    ST_PRE_N,
    ST_NUM,
    ST_SPACE,
    ST_CMD,
    ST_STAR,
    ST_CS,
    ST_NL
  } back_state_t;

endpackage

`default_nettype wire

// ----- hw/rtl/gcfrm_front.sv -----
// front part: accepts command bytes, marks line starts, queues them for the back part
`default_nettype none

module gcfrm_front (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire logic                push,
  output logic                     full,
  input  wire gcfrm_pkg::in_item_t in_item,
  output gcfrm_pkg::fq_head_t      fq_head,
  input  wire logic                fq_take
);
  import gcfrm_pkg::*;

  fq_item_t              mem_r [FQ_DEPTH];
  logic [FQ_PTR_W-1:0]   wr_ptr_r, wr_ptr_nxt;
  logic [FQ_PTR_W-1:0]   rd_ptr_r, rd_ptr_nxt;
  logic [FQ_CNT_W-1:0]   cnt_r, cnt_nxt;
  logic                  in_line_r, in_line_nxt;
  logic                  do_push, do_pop;
  fq_item_t              new_item;

  assign full    = (cnt_r == FQ_CNT_W'(FQ_DEPTH));
  assign do_push = push && !full;
  assign do_pop  = fq_take && (cnt_r != '0);

  assign fq_head.valid = (cnt_r != '0);
  assign fq_head.item  = mem_r[rd_ptr_r];

  // a byte starts a line unless the previous one left the line open
  always_comb begin
    new_item.cmd_byte   = in_item.cmd_byte;
    new_item.line_first = !in_line_r;
    new_item.line_last  = in_item.line_last;
  end

  always_comb begin
    wr_ptr_nxt  = wr_ptr_r;
    rd_ptr_nxt  = rd_ptr_r;
    cnt_nxt     = cnt_r;
    in_line_nxt = in_line_r;
    if (do_push) begin
      wr_ptr_nxt  = (wr_ptr_r == FQ_PTR_W'(FQ_DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
      in_line_nxt = !in_item.line_last;
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == FQ_PTR_W'(FQ_DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    if (do_push && !do_pop) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (!do_push && do_pop) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r  <= '0;
      rd_ptr_r  <= '0;
      cnt_r     <= '0;
      in_line_r <= 1'b0;
    end else begin
      wr_ptr_r  <= wr_ptr_nxt;
      rd_ptr_r  <= rd_ptr_nxt;
      cnt_r     <= cnt_nxt;
      in_line_r <= in_line_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= new_item;
    end
  end

endmodule

`default_nettype wire

// ----- hw/rtl/gcfrm_back.sv -----
// back part: line counter, running xor and the byte sequencer that frames each line
`default_nettype none

module gcfrm_back (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire gcfrm_pkg::fq_head_t fq_head,
  output logic                     fq_take,
  output gcfrm_pkg::oq_push_t      oq_push,
  input  wire logic                oq_ready
);
  import gcfrm_pkg::*;

  back_state_t                     state_r, state_nxt;
  fq_item_t                        cur_r, cur_nxt;
  logic [LINE_COUNT_BITS-1:0]      cnt_r, cnt_nxt;
  logic [BCD_DIGITS-1:0][3:0]      bcd_r, bcd_nxt;
  logic [DIG_IDX_W-1:0]            dig_idx_r, dig_idx_nxt;
  logic [7:0]                      xor_r, xor_nxt;
  logic [CS_DIGITS-1:0][3:0]       cs_dig_r, cs_dig_nxt;
  logic [CS_IDX_W-1:0]             cs_idx_r, cs_idx_nxt;

  logic                            emit;
  logic                            line_done;
  back_state_t                     load_state;
  out_item_t                       emit_item;
  logic [BCD_DIGITS-1:0][3:0]      bcd_inc;
  logic [DIG_IDX_W-1:0]            msd;
  logic [1:0]                      cs_h;
  logic [7:0]                      cs_r100;
  logic [14:0]                     cs_prod;
  logic [3:0]                      cs_t;
  logic [3:0]                      cs_o;

  assign emit       = (state_r != ST_FETCH) && oq_ready;
  // a byte that ends an item's output lets the next queued item load at once
  assign line_done  = emit && ((state_r == ST_CMD && !cur_r.line_last) || state_r == ST_NL);
  assign fq_take    = fq_head.valid && (state_r == ST_FETCH || line_done);
  assign load_state = fq_head.item.line_first ? ST_PRE_N : ST_CMD;

  // decimal increment, carry ripples through trailing nines
  always_comb begin
    logic carry;
    carry = 1'b1;
    for (int i = 0; i < BCD_DIGITS; i++) begin
      if (carry) begin
        bcd_inc[i] = (bcd_r[i] == 4'd9) ? 4'd0 : bcd_r[i] + 4'd1;
      end else begin
        bcd_inc[i] = bcd_r[i];
      end
      carry = carry && (bcd_r[i] == 4'd9);
    end
  end

  // highest nonzero digit, zero when the count is zero
  always_comb begin
    msd = '0;
    for (int i = 1; i < BCD_DIGITS; i++) begin
      if (bcd_r[i] != 4'd0) begin
        msd = DIG_IDX_W'(i);
      end
    end
  end

  // checksum to decimal: hundreds by compare, tens by reciprocal of ten
  always_comb begin
    if (xor_r >= 8'd200) begin
      cs_h    = 2'd2;
      cs_r100 = xor_r - 8'd200;
    end else if (xor_r >= 8'd100) begin
      cs_h    = 2'd1;
      cs_r100 = xor_r - 8'd100;
    end else begin
      cs_h    = 2'd0;
      cs_r100 = xor_r;
    end
    cs_prod = 15'(cs_r100) * 15'd205;
    cs_t    = cs_prod[14:11];
    cs_o    = 4'(cs_r100 - 8'(cs_t) * 8'd10);
  end

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_FETCH: begin
        if (fq_take) state_nxt = load_state;
      end
      ST_PRE_N: begin
        if (emit) state_nxt = ST_NUM;
      end
      ST_NUM: begin
        if (emit && dig_idx_r == '0) state_nxt = ST_SPACE;
      end
      ST_SPACE: begin
        if (emit) state_nxt = ST_CMD;
      end
      ST_CMD: begin
        if (emit) begin
          if (cur_r.line_last) state_nxt = ST_STAR;
          else if (fq_take)    state_nxt = load_state;
          else                 state_nxt = ST_FETCH;
        end
      end
      ST_STAR: begin
        if (emit) state_nxt = ST_CS;
      end
      ST_CS: begin
        if (emit && cs_idx_r == '0) state_nxt = ST_NL;
      end
      ST_NL: begin
        if (emit) state_nxt = fq_take ? load_state : ST_FETCH;
      end
      default: state_nxt = ST_FETCH;
    endcase
  end

  // byte produced in each state
  always_comb begin
    emit_item.out_byte = CH_NL;
    emit_item.run_last = 1'b0;
    emit_item.line_end = 1'b0;
    case (state_r)
      ST_PRE_N: emit_item.out_byte = CH_N;
      ST_NUM:   emit_item.out_byte = CH_ZERO + {4'd0, bcd_r[dig_idx_r]};
      ST_SPACE: emit_item.out_byte = CH_SPACE;
      ST_CMD: begin
        emit_item.out_byte = cur_r.cmd_byte;
        emit_item.run_last = !cur_r.line_last;
      end
      ST_STAR:  emit_item.out_byte = CH_STAR;
      ST_CS:    emit_item.out_byte = CH_ZERO + {4'd0, cs_dig_r[cs_idx_r]};
      ST_NL: begin
        emit_item.out_byte = CH_NL;
        emit_item.run_last = 1'b1;
        emit_item.line_end = 1'b1;
      end
      default: emit_item.out_byte = CH_NL;
    endcase
  end

  assign oq_push.valid = emit;
  assign oq_push.item  = emit_item;

  // datapath updates
  always_comb begin
    cur_nxt     = cur_r;
    cnt_nxt     = cnt_r;
    bcd_nxt     = bcd_r;
    dig_idx_nxt = dig_idx_r;
    xor_nxt     = xor_r;
    cs_dig_nxt  = cs_dig_r;
    cs_idx_nxt  = cs_idx_r;
    if (fq_take) begin
      cur_nxt = fq_head.item;
      if (fq_head.item.line_first) begin
        if (&cnt_r) begin
          cnt_nxt = '0;
          bcd_nxt = '0;
        end else begin
          cnt_nxt = cnt_r + 1'b1;
          bcd_nxt = bcd_inc;
        end
      end
    end
    if (emit) begin
      case (state_r)
        ST_PRE_N: begin
          xor_nxt     = CH_N;
          dig_idx_nxt = msd;
        end
        ST_NUM: begin
          xor_nxt     = xor_r ^ emit_item.out_byte;
          dig_idx_nxt = dig_idx_r - 1'b1;
        end
        ST_SPACE, ST_CMD: begin
          xor_nxt = xor_r ^ emit_item.out_byte;
        end
        ST_STAR: begin
          cs_dig_nxt[2] = {2'd0, cs_h};
          cs_dig_nxt[1] = cs_t;
          cs_dig_nxt[0] = cs_o;
          if (cs_h != 2'd0)      cs_idx_nxt = CS_IDX_W'(2);
          else if (cs_t != 4'd0) cs_idx_nxt = CS_IDX_W'(1);
          else                   cs_idx_nxt = '0;
        end
        ST_CS: begin
          cs_idx_nxt = cs_idx_r - 1'b1;
        end
        ST_NL: begin
          xor_nxt = '0;
        end
        default: xor_nxt = xor_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_FETCH;
      cnt_r   <= '0;
      bcd_r   <= '0;
      xor_r   <= '0;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
      bcd_r   <= bcd_nxt;
      xor_r   <= xor_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cur_r     <= cur_nxt;
    dig_idx_r <= dig_idx_nxt;
    cs_dig_r  <= cs_dig_nxt;
    cs_idx_r  <= cs_idx_nxt;
  end

`ifndef SYNTHESIS
  a_bcd_tracks_bin: assert property (@(posedge clk) disable iff (!rst_n)
    (cnt_r == '0) |-> (bcd_r == '0))
    else $error("decimal counter out of step with binary counter");

  a_open_line_no_start: assert property (@(posedge clk) disable iff (!rst_n)
    (fq_take && state_r == ST_CMD) |-> !fq_head.item.line_first)
    else $error("line start taken while a line is still open");

  a_closed_line_start: assert property (@(posedge clk) disable iff (!rst_n)
    (fq_take && state_r == ST_NL) |-> fq_head.item.line_first)
    else $error("byte after line end not marked as line start");

  a_digit_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_NUM) |-> (dig_idx_r <= DIG_IDX_W'(BCD_DIGITS - 1)))
    else $error("line number digit index out of range");
`endif

endmodule

`default_nettype wire

// ----- hw/rtl/gcfrm_outq.sv -----
// result queue between the sequencer and the output channel
`default_nettype none

module gcfrm_outq (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire gcfrm_pkg::oq_push_t oq_push,
  output logic                     oq_ready,
  output logic                     empty,
  input  wire logic                pop,
  output gcfrm_pkg::out_item_t     out_item
);
  import gcfrm_pkg::*;

  out_item_t             mem_r [OQ_DEPTH];
  logic [OQ_PTR_W-1:0]   wr_ptr_r, wr_ptr_nxt;
  logic [OQ_PTR_W-1:0]   rd_ptr_r, rd_ptr_nxt;
  logic [OQ_CNT_W-1:0]   cnt_r, cnt_nxt;
  logic                  do_push, do_pop;

  assign oq_ready = (cnt_r != OQ_CNT_W'(OQ_DEPTH));
  assign empty    = (cnt_r == '0);
  assign do_push  = oq_push.valid && oq_ready;
  assign do_pop   = pop && !empty;
  assign out_item = mem_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == OQ_PTR_W'(OQ_DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == OQ_PTR_W'(OQ_DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    if (do_push && !do_pop) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (!do_push && do_pop) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= oq_push.item;
    end
  end

endmodule

`default_nettype wire

// ----- hw/rtl/gcode_line_number_checksum_framer.sv -----
// top level of the g-code line framer with line number and xor checksum
//
// input channel: one raw command byte per transaction with a last-byte mark;
//   a transaction completes on a clock edge with push high and full low
// result channel: one byte of framed text per transaction; the oldest byte
//   sits on out_item while empty is low and leaves on an edge with pop high
// each line comes out as 'N', line number in decimal, ' ', the command bytes,
//   '*', xor checksum in decimal, newline; the first line after reset is N1
// path: an accepted byte is registered in the input queue, loaded into the sequencer
//   registers and written into the result queue before its first result shows on out_item
// throughput: one result byte per cycle while the result queue has room, set by the
//   single byte sequencer; a byte that opens a line first adds 'N', the line number and
//   ' ', one that closes a line adds '*', the checksum and newline; other bytes add none
// a four-entry queue decouples the input side from the sequencer, so input
//   keeps flowing during prefix and suffix bytes until that queue fills
// reset clears the counter, checksum and both queues; no clearing pass
// when the receiver holds pop low the two-entry result queue fills, the
//   sequencer waits, then the input queue fills and full rises
`default_nettype none

module gcode_line_number_checksum_framer (
  input  wire logic                clk,
  input  wire logic                rst_n,
  // input channel
  input  wire logic                push,
  output logic                     full,
  input  wire gcfrm_pkg::in_item_t in_item,
  // result channel
  output logic                     empty,
  input  wire logic                pop,
  output gcfrm_pkg::out_item_t     out_item
);
  import gcfrm_pkg::*;

  fq_head_t fq_head;   // oldest classified byte waiting for the sequencer
  logic     fq_take;   // sequencer takes that byte this cycle
  oq_push_t oq_push;   // byte produced by the sequencer
  logic     oq_ready;  // result queue has room

  // front: line-start marking and input queue
  gcfrm_front u_front (
    .clk     (clk),
    .rst_n   (rst_n),
    .push    (push),
    .full    (full),
    .in_item (in_item),
    .fq_head (fq_head),
    .fq_take (fq_take)
  );

  // back: counter, checksum and framing sequencer
  gcfrm_back u_back (
    .clk      (clk),
    .rst_n    (rst_n),
    .fq_head  (fq_head),
    .fq_take  (fq_take),
    .oq_push  (oq_push),
    .oq_ready (oq_ready)
  );

  // result queue so the sequencer keeps running while the receiver stalls, until the queue fills
  gcfrm_outq u_outq (
    .clk      (clk),
    .rst_n    (rst_n),
    .oq_push  (oq_push),
    .oq_ready (oq_ready),
    .empty    (empty),
    .pop      (pop),
    .out_item (out_item)
  );

endmodule

`default_nettype wire

// ----- dv/gcode_line_number_checksum_framer_test.sv -----
// self-checking testbench for the g-code line framer with line number and xor checksum
`timescale 1ns / 1ps

module gcode_line_number_checksum_framer_test;
  import gcfrm_pkg::*;

  // expected-byte tracker: mirrors the framer state and holds the framed text still owed
  class frame_scoreboard;
    logic [31:0] line_count;
    logic [7:0]  cs_acc;
    bit          in_line;
    out_item_t   expected_bytes[$];
    int          mismatches;
    int          lines_done;
    int          cmd_bytes;
    int          bytes_checked;
    int          cs_width_seen[4];

    function new();
      line_count = '0;
      cs_acc   = '0;
      in_line  = 1'b0;
      mismatches = 0;
      lines_done = 0;
      cmd_bytes = 0;
      bytes_checked = 0;
      foreach (cs_width_seen[i]) cs_width_seen[i] = 0;
    endfunction

    task report(string msg);
      $display("[%0t] mismatch: %s", $realtime, msg);
      mismatches++;
    endtask

    function string dec_text(logic [31:0] v);
      return $sformatf("%0d", v);
    endfunction

    function logic [31:0] wrap_count(logic [31:0] v);
      logic [63:0] nxt;
      nxt = ({32'd0, v} + 64'd1) & ((64'd1 << LINE_COUNT_BITS) - 64'd1);
      return nxt[31:0];
    endfunction

    function void emit(logic [7:0] b, bit fold, bit is_nl);
      out_item_t r;
      if (fold) cs_acc = cs_acc ^ b;
      r.out_byte = b;
      r.run_last = 1'b0;
      r.line_end = is_nl;
      expected_bytes.push_back(r);
    endfunction

    function int emit_decimal(logic [31:0] v, bit fold);
      string s;
      s = dec_text(v);
      for (int i = 0; i < s.len(); i++) emit(s[i], fold, 1'b0);
      return s.len();
    endfunction

    // xor of the prefix that the next line will open with
    function logic [7:0] next_prefix_xor();
      logic [7:0] acc;
      string s;
      acc = CH_N ^ CH_SPACE;
      s = dec_text(wrap_count(line_count));
      for (int i = 0; i < s.len(); i++) acc = acc ^ s[i];
      return acc;
    endfunction

    // one accepted command byte: prefix on a new line, the byte, suffix on the last one
    function void note_cmd_byte(in_item_t it);
      out_item_t tail;
      int w;
      if (!in_line) begin
        line_count = wrap_count(line_count);
        cs_acc = '0;
        emit(CH_N, 1'b1, 1'b0);
        void'(emit_decimal(line_count, 1'b1));
        emit(CH_SPACE, 1'b1, 1'b0);
        in_line = 1'b1;
      end
      emit(it.cmd_byte, 1'b1, 1'b0);
      cmd_bytes++;
      if (it.line_last) begin
        emit(CH_STAR, 1'b0, 1'b0);
        w = emit_decimal({24'd0, cs_acc}, 1'b0);
        emit(CH_NL, 1'b0, 1'b1);
        cs_width_seen[w]++;
        lines_done++;
        in_line = 1'b0;
        cs_acc = '0;
      end
      tail = expected_bytes.pop_back();
      tail.run_last = 1'b1;
      expected_bytes.push_back(tail);
    endfunction

    task check_frame_byte(out_item_t got);
      out_item_t want;
      bytes_checked++;
      if (expected_bytes.size() == 0) begin
        report($sformatf("byte 0x%02h arrived with nothing pending", got.out_byte));
        return;
      end
      want = expected_bytes.pop_front();
      if (got.out_byte !== want.out_byte)
        report($sformatf("out_byte 0x%02h, want 0x%02h", got.out_byte, want.out_byte));
      if (got.run_last !== want.run_last)
        report($sformatf("run_last %b, want %b (byte 0x%02h)",
                         got.run_last, want.run_last, want.out_byte));
      if (got.line_end !== want.line_end)
        report($sformatf("line_end %b, want %b (byte 0x%02h)",
                         got.line_end, want.line_end, want.out_byte));
    endtask
  endclass

  // receiver stall shape used in one of its modes
  localparam logic [7:0] STALL_PATTERN = 8'b1011_0110;
  localparam int         TARGET_ITEMS  = 200;

  logic      clk = 1'b0;
  logic      rst_n;
  logic      push;
  logic      full;
  in_item_t  in_item;
  logic      empty;
  logic      pop;
  out_item_t out_item;

  frame_scoreboard sb;
  int          burst_left = 0;
  int          items_sent = 0;
  int          pauses = 0;
  logic [7:0]  rx_cycle;

  always #6 clk = ~clk;

  gcode_line_number_checksum_framer u_dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (push),
    .full     (full),
    .in_item  (in_item),
    .empty    (empty),
    .pop      (pop),
    .out_item (out_item)
  );

  // hand one command byte to the framer; the sender runs in bursts with idle gaps
  // between them, and a gap of zero gives back-to-back bursts with no idling at all
  task automatic send_byte(input logic [7:0] b, input bit last);
    int gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
      if (gap > 0) begin
        push <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      burst_left = $urandom_range(1, 24);
    end
    burst_left--;
    in_item <= '{cmd_byte: b, line_last: last};
    push    <= 1'b1;
    // full is sampled as it was just before the edge, so the transaction happens
    // exactly at the first edge that sees it low
    @(posedge clk);
    while (full) @(posedge clk);
    sb.note_cmd_byte('{cmd_byte: b, line_last: last});
    items_sent++;
  endtask

  // a two-byte line whose last byte is chosen so the checksum lands on target
  task automatic send_line_for_checksum(input logic [7:0] target, input logic [7:0] lead);
    logic [7:0] acc;
    acc = sb.next_prefix_xor() ^ lead;
    send_byte(lead, 1'b0);
    send_byte(acc ^ target, 1'b1);
  endtask

  // g-code text mostly, with full-range bytes mixed in so every bit toggles
  task automatic send_random_line();
    string gcode_chars;
    int    len;
    logic [7:0] b;
    gcode_chars = "G0123456789XYZEFMST. -;";
    len = ($urandom_range(0, 9) < 8) ? $urandom_range(1, 8) : $urandom_range(9, 40);
    for (int i = 0; i < len; i++) begin
      if ($urandom_range(0, 9) < 7)
        b = gcode_chars[$urandom_range(0, gcode_chars.len() - 1)];
      else
        b = 8'($urandom_range(0, 255));
      send_byte(b, i == len - 1);
    end
  endtask

  // hold the input off until every owed byte has come out
  task automatic drain_outputs();
    push <= 1'b0;
    burst_left = 0;
    while (sb.expected_bytes.size() != 0) @(posedge clk);
    pauses++;
  endtask

  // receiver: checks each transaction on the result side, then picks the next pop;
  // the stall style follows the top two bits of the receiver's cycle count: always ready,
  // random, a fixed pattern, and long stalls that back the framer up into full
  always @(posedge clk) begin
    if (!rst_n) begin
      pop      <= 1'b0;
      rx_cycle <= '0;
    end else begin
      if (pop && !empty) sb.check_frame_byte(out_item);
      rx_cycle <= rx_cycle + 8'd1;
      case (rx_cycle[7:6])
        2'd0: begin
          pop <= 1'b1;
        end
        2'd1: begin
          pop <= ($urandom_range(0, 3) != 0);
        end
        2'd2: begin
          pop <= STALL_PATTERN[rx_cycle[2:0]];
        end
        default: begin
          pop <= (rx_cycle[3:0] >= 4'd10);
        end
      endcase
    end
  end

  initial begin
    int drain_cycles;
    sb      = new();
    rst_n   = 1'b0;
    push    = 1'b0;
    in_item = '0;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed: one-byte line first, so it also carries line number one
    send_byte("G", 1'b1);
    // nul and all-ones bytes pass through and fold into the checksum
    send_byte(8'h00, 1'b0);
    send_byte(8'hFF, 1'b1);
    // checksums of one, two and three digits, zero and the extremes included
    send_line_for_checksum(8'd0, "M");
    send_line_for_checksum(8'd9, "G");
    send_line_for_checksum(8'd10, "X");
    send_line_for_checksum(8'd99, "Y");
    send_line_for_checksum(8'd100, "Z");
    send_line_for_checksum(8'd255, 8'h80);
    send_line_for_checksum(8'd7, 8'h01);
    // line numbers cross into two digits here
    send_byte("T", 1'b0);
    send_byte(8'h55, 1'b0);
    send_byte(8'hAA, 1'b1);
    drain_outputs();

    // random lines; now and then the sender waits for the framer to empty out
    while (items_sent < TARGET_ITEMS) begin
      send_random_line();
      if ($urandom_range(0, 11) == 0) drain_outputs();
    end

    push <= 1'b0;
    drain_cycles = 0;
    while (sb.expected_bytes.size() != 0 && drain_cycles < 20000) begin
      @(posedge clk);
      drain_cycles++;
    end
    // wait on so any stray extra byte is seen
    repeat (16) @(posedge clk);
    if (sb.expected_bytes.size() != 0)
      sb.report($sformatf("%0d framed bytes never arrived", sb.expected_bytes.size()));

    $display("covered %0d command bytes in %0d lines, %0d framed bytes checked, %0d drains",
             sb.cmd_bytes, sb.lines_done, sb.bytes_checked, pauses);
    $display("checksums with 1/2/3 digits: %0d/%0d/%0d, last line number %0d",
             sb.cs_width_seen[1], sb.cs_width_seen[2], sb.cs_width_seen[3], sb.line_count);
    if (sb.mismatches == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

  // watchdog, far beyond the slowest legal run
  initial begin
    #5_000_000;
    $display("[FAIL] regression broken");
    $finish;
  end

endmodule
